// ----- rtl/hse_pkg.sv -----
// ----------------------------------------------------------------------------
// hse_pkg
// shared widths and defaults for the heap sort engine
// ----------------------------------------------------------------------------
package hse_pkg;

	localparam int DATA_W   = 32;
	localparam int CAPACITY = 64;

endpackage

// ----- rtl/hse_in_if.sv -----
// ----------------------------------------------------------------------------
// hse_in_if
// input channel: one element of the set per beat, last beat marked
// ----------------------------------------------------------------------------
interface hse_in_if;

	logic                             valid;
	logic                             ready;
	logic signed [hse_pkg::DATA_W-1:0] value;
	logic                             last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);

endinterface

// ----- rtl/hse_out_if.sv -----
// ----------------------------------------------------------------------------
// hse_out_if
// result channel: sorted elements in ascending order, one per beat
// ----------------------------------------------------------------------------
interface hse_out_if;

	logic                             valid;
	logic                             ready;
	logic signed [hse_pkg::DATA_W-1:0] sorted_value;
	logic                             end_of_run;
	logic                             dropped;

	modport source (output valid, output sorted_value, output end_of_run, output dropped,
		input ready);
	modport sink (input valid, input sorted_value, input end_of_run, input dropped,
		output ready);

endinterface

// ----- rtl/heap_sort_engine_top.sv -----
// ----------------------------------------------------------------------------
// heap_sort_engine_top
// in-place heap sort of one set of signed 32-bit values per run
// ----------------------------------------------------------------------------
// Elements are loaded at one beat per cycle into a CAPACITY-entry store; elements
// that arrive while the store is full are discarded and every result of that set
// carries the dropped flag. After the last beat the block stops accepting input,
// builds a max-heap and extracts the root repeatedly, then returns the n stored
// values in ascending order, end_of_run on the largest. All ordering goes through
// one signed 32-bit comparator and a store with two registered read ports and one
// write port: each sift starts through FETCH and TAKE (build) or SWAP_RD and SWAP_WR
// (extract), and each level of it steps through SIFT_RD, SIFT_SEL and SIFT_CMP; each
// result is read, loaded and held until the sink takes it before the next is read.
// ----------------------------------------------------------------------------
module heap_sort_engine_top #(
	parameter int CAPACITY = hse_pkg::CAPACITY
) (
	input  logic       clk,
	input  logic       arst_n,
	hse_in_if.sink     item,
	hse_out_if.source  result
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = $clog2(2 * CAPACITY + 1);
	localparam int DW = hse_pkg::DATA_W;

	typedef enum logic [3:0] {
		LOAD,
		FETCH,
		TAKE,
		SIFT_RD,
		SIFT_SEL,
		SIFT_CMP,
		NEXT,
		SWAP_RD,
		SWAP_WR,
		EMIT_RD,
		EMIT_LD,
		EMIT_WAIT
	} state_t;

	state_t state_q;

	logic [DW-1:0] heap_q [CAPACITY];
	logic [DW-1:0] rdata0_q, rdata1_q;

	logic [CW-1:0] cnt_q, size_q, cnt_nxt;
	logic          ovf_q, build_q;
	logic [AW-1:0] top_q, ext_q, node_q, child_q, idx_q;
	logic [DW-1:0] cur_q, childv_q;

	logic          out_valid_q, out_end_q, out_drop_q;
	logic [DW-1:0] out_data_q;

	logic [AW-1:0] raddr0, raddr1, waddr;
	logic          we;
	logic [DW-1:0] wdata;
	logic signed [DW-1:0] cmp_a, cmp_b;
	logic          cmp_gt;
	logic [LW-1:0] lc, rc;
	logic          lc_in, rc_in, accept, full;

	assign item.ready          = (state_q == LOAD);
	assign accept              = item.valid && item.ready;
	assign full                = (cnt_q == CW'(CAPACITY));
	assign cnt_nxt             = full ? cnt_q : cnt_q + CW'(1);
	assign lc                  = (LW'(node_q) << 1) + LW'(1);
	assign rc                  = lc + LW'(1);
	assign lc_in               = (lc < LW'(size_q));
	assign rc_in               = (rc < LW'(size_q));
	assign cmp_gt              = (cmp_a > cmp_b);
	assign result.valid        = out_valid_q;
	assign result.sorted_value = out_data_q;
	assign result.end_of_run   = out_end_q;
	assign result.dropped      = out_drop_q;

	// store port control and shared comparator operands
	always_comb begin
		raddr0 = '0;
		raddr1 = '0;
		we     = 1'b0;
		waddr  = node_q;
		wdata  = cur_q;
		cmp_a  = rdata1_q;
		cmp_b  = rdata0_q;
		unique case (state_q)
			LOAD: begin
				we    = accept && !full;
				waddr = cnt_q[AW-1:0];
				wdata = item.value;
			end
			FETCH:   raddr0 = top_q;
			SWAP_RD: begin
				raddr0 = '0;
				raddr1 = ext_q;
			end
			SWAP_WR: begin
				we    = 1'b1;
				waddr = ext_q;
				wdata = rdata0_q;
			end
			SIFT_RD: begin
				raddr0 = lc[AW-1:0];
				raddr1 = rc[AW-1:0];
				we     = !lc_in;
			end
			SIFT_SEL: begin
				cmp_a = rdata1_q;
				cmp_b = rdata0_q;
			end
			SIFT_CMP: begin
				cmp_a = childv_q;
				cmp_b = cur_q;
				we    = 1'b1;
				wdata = cmp_gt ? childv_q : cur_q;
			end
			EMIT_RD: raddr0 = idx_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			heap_q[waddr] <= wdata;
		end
		rdata0_q <= heap_q[raddr0];
		rdata1_q <= heap_q[raddr1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			build_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				LOAD: begin
					if (accept) begin
						cnt_q <= cnt_nxt;
						if (full) begin
							ovf_q <= 1'b1;
						end
						if (item.last) begin
							if (cnt_nxt >= CW'(2)) begin
								top_q   <= AW'((cnt_nxt >> 1) - CW'(1));
								build_q <= 1'b1;
								state_q <= FETCH;
							end else begin
								idx_q   <= '0;
								state_q <= EMIT_RD;
							end
						end
					end
				end
				FETCH: state_q <= TAKE;
				TAKE: begin
					cur_q   <= rdata0_q;
					node_q  <= top_q;
					size_q  <= cnt_q;
					state_q <= SIFT_RD;
				end
				SIFT_RD: state_q <= lc_in ? SIFT_SEL : NEXT;
				SIFT_SEL: begin
					if (rc_in && cmp_gt) begin
						child_q  <= rc[AW-1:0];
						childv_q <= rdata1_q;
					end else begin
						child_q  <= lc[AW-1:0];
						childv_q <= rdata0_q;
					end
					state_q <= SIFT_CMP;
				end
				SIFT_CMP: begin
					if (cmp_gt) begin
						node_q  <= child_q;
						state_q <= SIFT_RD;
					end else begin
						state_q <= NEXT;
					end
				end
				NEXT: begin
					if (build_q) begin
						if (top_q == '0) begin
							build_q <= 1'b0;
							ext_q   <= AW'(cnt_q - CW'(1));
							state_q <= SWAP_RD;
						end else begin
							top_q   <= top_q - AW'(1);
							state_q <= FETCH;
						end
					end else if (ext_q == AW'(1)) begin
						idx_q   <= '0;
						state_q <= EMIT_RD;
					end else begin
						ext_q   <= ext_q - AW'(1);
						state_q <= SWAP_RD;
					end
				end
				SWAP_RD: state_q <= SWAP_WR;
				SWAP_WR: begin
					cur_q   <= rdata1_q;
					node_q  <= '0;
					size_q  <= CW'(ext_q);
					state_q <= SIFT_RD;
				end
				EMIT_RD: state_q <= EMIT_LD;
				EMIT_LD: begin
					out_data_q  <= rdata0_q;
					out_end_q   <= (CW'(idx_q) == cnt_q - CW'(1));
					out_drop_q  <= ovf_q;
					out_valid_q <= 1'b1;
					state_q     <= EMIT_WAIT;
				end
				EMIT_WAIT: begin
					if (result.ready) begin
						out_valid_q <= 1'b0;
						if (out_end_q) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= LOAD;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= EMIT_RD;
						end
					end
				end
				default: state_q <= LOAD;
			endcase
		end
	end

`ifndef SYNTHESIS
	// no input beat is taken while a result is pending
	assert property (@(posedge clk) disable iff (!arst_n) item.ready |-> !result.valid)
		else $error("input accepted while a result is pending");

	// the element count never passes the store size
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(CAPACITY))
		else $error("element count beyond capacity");

	// the final beat of a run returns the block to an empty load phase
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && result.end_of_run |=>
		item.ready && cnt_q == '0 && !ovf_q)
		else $error("run did not restart after final beat");

	// a drop is only recorded once the store is full
	assert property (@(posedge clk) disable iff (!arst_n) $rose(ovf_q) |-> cnt_q == CW'(CAPACITY))
		else $error("overflow flagged with room left");
`endif

endmodule
